>>> rtl/sbt_pkg.sv
// Package for the sorted block table: widths, action, order and status codes, states.
// No dependencies.
`timescale 1ns / 1ps
package sbt_pkg;
  localparam int unsigned DefEntries = 32;
  localparam int unsigned DefAddrBits = 16;
  localparam int unsigned FieldW = 16;

  typedef enum logic [2:0] {
    ACT_INSERT = 3'd0,
    ACT_REM_HEAD = 3'd1,
    ACT_REM_IDX = 3'd2,
    ACT_FIND = 3'd3,
    ACT_COALESCE = 3'd4,
    ACT_CLEAR = 3'd5,
    ACT_NOP6 = 3'd6,
    ACT_NOP7 = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ORD_BACK = 3'd0,
    ORD_FRONT = 3'd1,
    ORD_START = 3'd2,
    ORD_ASIZE = 3'd3,
    ORD_DSIZE = 3'd4
  } order_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH,
    S_INS_RD,
    S_INS,
    S_INS_PUT,
    S_RM_RD,
    S_RM,
    S_CO_RD,
    S_CO,
    S_DONE
  } state_t;
endpackage

>>> rtl/sbt_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module sbt_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/sbt_ctrl.sv
// Sequencer for the sorted block table: walks the RAM one entry per cycle.
// Depends on sbt_pkg; drives one sbt_ram port pair.
`timescale 1ns / 1ps
module sbt_ctrl import sbt_pkg::*; #(
  parameter int unsigned Entries = DefEntries,
  parameter int unsigned AddrBits = DefAddrBits
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_action,
  input  logic [FieldW-1:0]             in_block_start,
  input  logic [FieldW-1:0]             in_block_end,
  input  logic [FieldW-1:0]             in_block_owner,
  input  logic [4:0]                    in_position,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_wdata,
  output logic                          ram_we,
  output logic [$clog2(Entries)-1:0]    ram_waddr,
  output logic [2*AddrBits+FieldW-1:0]  ram_wdata,
  output logic [$clog2(Entries)-1:0]    ram_raddr,
  input  logic [2*AddrBits+FieldW-1:0]  ram_rdata,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [FieldW-1:0]             out_start,
  output logic [FieldW-1:0]             out_end,
  output logic [FieldW-1:0]             out_owner,
  output logic [4:0]                    out_found_index,
  output logic [5:0]                    out_entry_count
);
  localparam int unsigned IW = $clog2(Entries);
  localparam int unsigned CW = $clog2(Entries + 1);
  localparam int unsigned AW = AddrBits;
  localparam int unsigned EW = 2 * AW + FieldW;

  state_t state_r, state_nxt;
  logic [2:0] order_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  action_t act_r, act_nxt;
  logic [AW-1:0] ns_r, ne_r;
  logic [FieldW-1:0] no_r;
  logic [EW-1:0] hold_r, hold_nxt;
  logic [1:0] st_r, st_nxt;
  logic [EW-1:0] res_r, res_nxt;
  logic [4:0] fidx_r, fidx_nxt;
  logic ov_r, ov_nxt;

  logic [AW-1:0] e_s, e_e, h_e;
  logic [FieldW-1:0] e_o;
  logic signed [AW+1:0] nsz, esz;
  logic new_first;
  logic [AW:0] h_end_p1;

  assign e_s = ram_rdata[EW-1:AW+FieldW];
  assign e_e = ram_rdata[AW+FieldW-1:FieldW];
  assign e_o = ram_rdata[FieldW-1:0];
  assign h_e = hold_r[AW+FieldW-1:FieldW];
  assign nsz = $signed({2'b00, ne_r}) - $signed({2'b00, ns_r}) + $signed((AW+2)'(1));
  assign esz = $signed({2'b00, e_e}) - $signed({2'b00, e_s}) + $signed((AW+2)'(1));
  assign h_end_p1 = {1'b0, h_e} + 1'b1;

  always_comb begin
    unique case (order_r)
      ORD_START: new_first = (idx_r == '0) ? (ns_r < e_s) : (e_s >= ns_r);
      ORD_ASIZE: new_first = nsz < esz;
      ORD_DSIZE: new_first = nsz > esz;
      default:   new_first = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      order_r <= ORD_START;
      count_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) begin
        order_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    act_r <= act_nxt;
    hold_r <= hold_nxt;
    st_r <= st_nxt;
    res_r <= res_nxt;
    fidx_r <= fidx_nxt;
    if (state_r == S_IDLE && start) begin
      ns_r <= AW'(in_block_start);
      ne_r <= AW'(in_block_end);
      no_r <= in_block_owner;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    pos_nxt = pos_r;
    act_nxt = act_r;
    hold_nxt = hold_r;
    st_nxt = st_r;
    res_nxt = res_r;
    fidx_nxt = fidx_r;
    ov_nxt = 1'b0;
    ram_we = 1'b0;
    ram_waddr = idx_r[IW-1:0];
    ram_wdata = hold_r;
    ram_raddr = idx_r[IW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt = action_t'(in_action);
          st_nxt = ST_DONE;
          res_nxt = '0;
          fidx_nxt = '0;
          idx_nxt = '0;
          unique case (action_t'(in_action))
            ACT_INSERT: begin
              if (count_r >= CW'(Entries)) begin
                st_nxt = ST_FULL;
                state_nxt = S_DONE;
              end else if (order_r == ORD_FRONT || count_r == '0) begin
                pos_nxt = '0;
                idx_nxt = count_r;
                state_nxt = (count_r == '0) ? S_INS_PUT : S_INS_RD;
              end else if (order_r == ORD_START || order_r == ORD_ASIZE
                           || order_r == ORD_DSIZE) begin
                state_nxt = S_SRCH_RD;
              end else begin
                pos_nxt = count_r;
                idx_nxt = count_r;
                state_nxt = S_INS_PUT;
              end
            end
            ACT_REM_HEAD, ACT_REM_IDX: begin
              if (action_t'(in_action) == ACT_REM_IDX) begin
                idx_nxt = CW'(in_position);
              end
              if ((action_t'(in_action) == ACT_REM_IDX
                   && 32'(in_position) >= 32'(count_r)) || count_r == '0) begin
                st_nxt = ST_MISS;
                state_nxt = S_DONE;
              end else begin
                pos_nxt = '0;
                state_nxt = S_RM_RD;
              end
            end
            ACT_FIND: begin
              st_nxt = ST_MISS;
              state_nxt = (count_r == '0) ? S_DONE : S_SRCH_RD;
            end
            ACT_COALESCE: state_nxt = (count_r < CW'(2)) ? S_DONE : S_CO_RD;
            ACT_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_SRCH_RD: state_nxt = S_SRCH;
      S_SRCH: begin
        if (act_r == ACT_FIND) begin
          if (e_o == no_r) begin
            st_nxt = ST_DONE;
            res_nxt = ram_rdata;
            fidx_nxt = 5'(idx_r);
            state_nxt = S_DONE;
          end else if (idx_r + 1'b1 >= count_r) begin
            state_nxt = S_DONE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            ram_raddr = idx_nxt[IW-1:0];
          end
        end else begin
          if (new_first || idx_r + 1'b1 >= count_r) begin
            pos_nxt = new_first ? idx_r : count_r;
            idx_nxt = count_r;
            state_nxt = (new_first) ? S_INS_RD : S_INS_PUT;
          end else begin
            idx_nxt = idx_r + 1'b1;
            ram_raddr = idx_nxt[IW-1:0];
          end
        end
      end
      S_INS_RD: begin
        ram_raddr = IW'(idx_r - 1'b1);
        state_nxt = S_INS;
      end
      S_INS: begin
        ram_we = 1'b1;
        ram_wdata = ram_rdata;
        idx_nxt = idx_r - 1'b1;
        ram_raddr = IW'(idx_nxt - 1'b1);
        if (idx_nxt == pos_r) begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        ram_we = 1'b1;
        ram_waddr = pos_r[IW-1:0];
        ram_wdata = {ns_r, ne_r, no_r};
        count_nxt = count_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_RM_RD: state_nxt = S_RM;
      S_RM: begin
        if (pos_r == '0) begin
          res_nxt = ram_rdata;
          pos_nxt = CW'(1);
        end else begin
          ram_we = 1'b1;
          ram_waddr = IW'(idx_r - 1'b1);
          ram_wdata = ram_rdata;
        end
        if (idx_r + 1'b1 >= count_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
          ram_raddr = idx_nxt[IW-1:0];
        end
      end
      // idx_r: entry on the read data; pos_r: write slot; hold_r: current entry
      S_CO_RD: begin
        pos_nxt = '0;
        state_nxt = S_CO;
      end
      S_CO: begin
        if (idx_r == '0) begin
          hold_nxt = ram_rdata;
        end else if (!h_end_p1[AW] && h_end_p1[AW-1:0] == e_s) begin
          hold_nxt = {hold_r[EW-1:AW+FieldW], e_e, hold_r[FieldW-1:0]};
        end else begin
          ram_we = 1'b1;
          ram_waddr = pos_r[IW-1:0];
          ram_wdata = hold_r;
          pos_nxt = pos_r + 1'b1;
          hold_nxt = ram_rdata;
        end
        idx_nxt = idx_r + 1'b1;
        ram_raddr = idx_nxt[IW-1:0];
        if (idx_r >= count_r) begin
          ram_we = 1'b1;
          ram_waddr = pos_r[IW-1:0];
          ram_wdata = hold_r;
          hold_nxt = hold_r;
          pos_nxt = pos_r;
          count_nxt = pos_r + 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = st_r;
  assign out_start = FieldW'(res_r[EW-1:AW+FieldW]);
  assign out_end = FieldW'(res_r[AW+FieldW-1:FieldW]);
  assign out_owner = res_r[FieldW-1:0];
  assign out_found_index = fidx_r;
  assign out_entry_count = 6'(count_r);
endmodule

>>> rtl/sorted_block_table_with_coalesce_core.sv
// Top level of the sorted block table: sequencer plus entry RAM.
// Depends on sbt_pkg, sbt_ctrl, sbt_ram.
`timescale 1ns / 1ps
// Usage:
// Drive in_* with start high while busy is low; the word is taken on that edge.
// busy stays high until the cycle the result word is shown; out_valid is high
// for that one cycle with status, block fields, found_index and entry_count,
// and busy is already low then, so the next word can be taken at its end.
// The receiver cannot stall; results are never held.
// The time from the accepting edge to the edge that takes the result, which is
// also the earliest next accept, grows with the entry count for remove, find,
// coalesce, insert at the front and sorted insert; it does not for clear, no-op,
// a failed insert or remove, or insert at the back or into an empty table.
// The entry RAM has one read and one write port; the walk moves one entry a cycle.
// Reset (rst_n low, synchronous) empties the table and sets insert order to
// ascending start. RAM contents are not cleared; entries beyond the count
// are never used. cfg_we writes insert_order at any edge; write it while idle.
module sorted_block_table_with_coalesce_core import sbt_pkg::*; #(
  parameter int unsigned Entries = DefEntries,
  parameter int unsigned AddrBits = DefAddrBits
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        in_action,
  input  logic [FieldW-1:0] in_block_start,
  input  logic [FieldW-1:0] in_block_end,
  input  logic [FieldW-1:0] in_block_owner,
  input  logic [4:0]        in_position,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_wdata,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [FieldW-1:0] out_start,
  output logic [FieldW-1:0] out_end,
  output logic [FieldW-1:0] out_owner,
  output logic [4:0]        out_found_index,
  output logic [5:0]        out_entry_count
);
  localparam int unsigned IW = $clog2(Entries);
  localparam int unsigned EW = 2 * AddrBits + FieldW;
  logic ram_we;
  logic [IW-1:0] ram_waddr, ram_raddr;
  logic [EW-1:0] ram_wdata, ram_rdata;

  sbt_ctrl #(.Entries(Entries), .AddrBits(AddrBits)) u_ctrl (
    .clk, .rst_n, .start, .busy, .in_action, .in_block_start, .in_block_end,
    .in_block_owner, .in_position, .cfg_we, .cfg_wdata, .ram_we, .ram_waddr,
    .ram_wdata, .ram_raddr, .ram_rdata, .out_valid, .out_status, .out_start,
    .out_end, .out_owner, .out_found_index, .out_entry_count
  );

  sbt_ram #(.Width(EW), .Depth(Entries)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );
endmodule

>>> rtl/sbt_checker.sv
// Port-level checks for the sorted block table, bound to the top level.
// Depends on sbt_pkg.
`timescale 1ns / 1ps
module sbt_checker import sbt_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [5:0] out_entry_count
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accept did not raise busy");
  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result longer than one cycle");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_entry_count <= 6'd32) else $error("count too large");
  a_full_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> $stable(out_entry_count))
    else $error("count changed on full");
endmodule

bind sorted_block_table_with_coalesce_core sbt_checker u_sbt_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_status, .out_entry_count
);

>>> dv/tb_top.sv
// Testbench for sorted_block_table_with_coalesce_core: directed rows, table fills,
// then random words, each result checked against an in-bench table predictor.
// Depends on sbt_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_top;
  import sbt_pkg::*;

  localparam int Depth = 32;
  localparam int RandWords = 540;
  localparam int CycleLimit = 400000;

  typedef struct packed {
    logic [15:0] bstart;
    logic [15:0] bend;
    logic [15:0] bowner;
  } blk_t;

  typedef struct {
    logic [1:0]  status;
    logic [15:0] rstart;
    logic [15:0] rend;
    logic [15:0] rowner;
    logic [4:0]  fidx;
    logic [5:0]  cnt;
  } res_t;

  typedef struct {
    logic [2:0]  act;
    logic [15:0] bs;
    logic [15:0] be;
    logic [15:0] bo;
    logic [4:0]  pos;
    logic        typed;
    logic [1:0]  status;
    logic [5:0]  cnt;
  } row_t;

  logic clk = 0, rst_n = 0, start = 0, cfg_we = 0;
  logic busy, out_valid;
  logic [2:0] in_action = '0, cfg_wdata = '0;
  logic [15:0] in_block_start = '0, in_block_end = '0, in_block_owner = '0;
  logic [4:0] in_position = '0;
  logic [1:0] out_status;
  logic [15:0] out_start, out_end, out_owner;
  logic [4:0] out_found_index;
  logic [5:0] out_entry_count;

  blk_t tbl[Depth];
  int tbl_cnt;
  logic [2:0] order_reg;
  res_t pending_res[$];
  row_t typed_rows[$];
  int errors = 0, words_sent = 0, results_seen = 0, cycles = 0;

  sorted_block_table_with_coalesce_core dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
    errors++;
    $display("mismatch %s: got %0h exp %0h at word %0d", what, got, exp, results_seen);
  endtask

  function automatic longint blk_size(blk_t b);
    return longint'(b.bend) - longint'(b.bstart) + 1;
  endfunction

  function automatic bit ahead_of(blk_t nb, int i);
    case (order_reg)
      ORD_START: return (i == 0) ? (nb.bstart < tbl[0].bstart) : (tbl[i].bstart >= nb.bstart);
      ORD_ASIZE: return blk_size(nb) < blk_size(tbl[i]);
      ORD_DSIZE: return blk_size(nb) > blk_size(tbl[i]);
      default: return 0;
    endcase
  endfunction

  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < tbl_cnt; i++) tbl[i] = tbl[i + 1];
    tbl_cnt--;
  endfunction

  function automatic res_t table_step(logic [2:0] act, blk_t nb, logic [4:0] pos);
    res_t r;
    int p, idx;
    r = '{default: '0};
    case (act)
      ACT_INSERT: begin
        if (tbl_cnt >= Depth) r.status = ST_FULL;
        else begin
          p = tbl_cnt;
          if (order_reg == ORD_FRONT) p = 0;
          else for (int i = 0; i < tbl_cnt; i++) if (ahead_of(nb, i)) begin
            p = i;
            break;
          end
          for (int i = tbl_cnt; i > p; i--) tbl[i] = tbl[i - 1];
          tbl[p] = nb;
          tbl_cnt++;
        end
      end
      ACT_REM_HEAD, ACT_REM_IDX: begin
        idx = (act == ACT_REM_HEAD) ? 0 : int'(pos);
        if (idx >= tbl_cnt) r.status = ST_MISS;
        else begin
          r.rstart = tbl[idx].bstart; r.rend = tbl[idx].bend; r.rowner = tbl[idx].bowner;
          drop_entry(idx);
        end
      end
      ACT_FIND: begin
        r.status = ST_MISS;
        for (int i = 0; i < tbl_cnt; i++) if (tbl[i].bowner == nb.bowner) begin
          r.status = ST_DONE;
          r.rstart = tbl[i].bstart; r.rend = tbl[i].bend; r.rowner = tbl[i].bowner;
          r.fidx = i[4:0];
          break;
        end
      end
      ACT_COALESCE: begin
        idx = 0;
        while (idx + 1 < tbl_cnt) begin
          if ({1'b0, tbl[idx].bend} + 17'd1 == {1'b0, tbl[idx + 1].bstart}) begin
            tbl[idx].bend = tbl[idx + 1].bend;
            drop_entry(idx + 1);
          end else idx++;
        end
      end
      ACT_CLEAR: tbl_cnt = 0;
      default: ;
    endcase
    r.cnt = tbl_cnt[5:0];
    return r;
  endfunction

  // result monitor
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_res.size() == 0) report("unexpected word", 0, 0);
      else begin
        e = pending_res.pop_front();
        if (out_status !== e.status) report("status", out_status, e.status);
        if (out_start !== e.rstart) report("start", out_start, e.rstart);
        if (out_end !== e.rend) report("end", out_end, e.rend);
        if (out_owner !== e.rowner) report("owner", out_owner, e.rowner);
        if (out_found_index !== e.fidx) report("found_index", out_found_index, e.fidx);
        if (out_entry_count !== e.cnt) report("entry_count", out_entry_count, e.cnt);
      end
    end
  end

  // start stays high after the accepting edge; callers drop it before any gap
  task automatic send_word(logic [2:0] act, logic [15:0] bs, logic [15:0] be,
                           logic [15:0] bo, logic [4:0] pos);
    res_t r;
    start <= 1; in_action <= act; in_block_start <= bs; in_block_end <= be;
    in_block_owner <= bo; in_position <= pos;
    r = table_step(act, '{bs, be, bo}, pos);
    pending_res.push_back(r);
    words_sent++;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_row(row_t rw);
    res_t r;
    send_word(rw.act, rw.bs, rw.be, rw.bo, rw.pos);
    r = pending_res[$];
    if (rw.typed && (r.status !== rw.status || r.cnt !== rw.cnt)) report("table row", 0, 0);
  endtask

  task automatic drain_and_set(logic [2:0] ord);
    start <= 0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1; cfg_wdata <= ord;
    @(posedge clk);
    cfg_we <= 0;
    order_reg = (ord > ORD_DSIZE) ? ORD_BACK : ord;
  endtask

  task automatic add_row(logic [2:0] a, logic [15:0] s, logic [15:0] e, logic [15:0] o,
                         logic [4:0] p, logic t, logic [1:0] st, logic [5:0] c);
    typed_rows.push_back('{a, s, e, o, p, t, st, c});
  endtask

  function automatic logic [15:0] rnd16();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    logic [15:0] s, e;
    int burst;
    tbl_cnt = 0;
    order_reg = ORD_START;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    add_row(ACT_REM_HEAD, 0, 0, 0, 0, 1, ST_MISS, 0);
    add_row(ACT_REM_IDX, 0, 0, 0, 31, 1, ST_MISS, 0);
    add_row(ACT_FIND, 0, 0, 16'h1234, 0, 1, ST_MISS, 0);
    add_row(ACT_COALESCE, 0, 0, 0, 0, 1, ST_DONE, 0);
    add_row(ACT_INSERT, 16'h0010, 16'h001f, 1, 0, 1, ST_DONE, 1);
    add_row(ACT_INSERT, 16'h0000, 16'h000f, 2, 0, 1, ST_DONE, 2);
    add_row(ACT_INSERT, 16'h0020, 16'h0010, 3, 0, 1, ST_DONE, 3);
    add_row(ACT_INSERT, 16'hffff, 16'hffff, 16'hffff, 0, 1, ST_DONE, 4);
    add_row(ACT_INSERT, 16'h0010, 16'h0010, 4, 0, 1, ST_DONE, 5);
    add_row(ACT_FIND, 0, 0, 16'hffff, 0, 0, 0, 0);
    add_row(ACT_FIND, 0, 0, 16'h0003, 0, 0, 0, 0);
    add_row(ACT_COALESCE, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_REM_IDX, 0, 0, 0, 1, 0, 0, 0);
    add_row(ACT_NOP6, 16'hffff, 16'hffff, 16'hffff, 31, 0, 0, 0);
    add_row(ACT_NOP7, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_REM_HEAD, 0, 0, 0, 0, 0, 0, 0);
    add_row(ACT_CLEAR, 0, 0, 0, 0, 1, ST_DONE, 0);
    foreach (typed_rows[i]) send_row(typed_rows[i]);

    // fill to full under each order, hit the full case, then find, remove and coalesce
    for (int o = 0; o < 8; o++) begin
      drain_and_set(o[2:0]);
      send_word(ACT_CLEAR, 0, 0, 0, 0);
      for (int k = 0; k < 33; k++) begin
        s = 16'($urandom_range(0, 300));
        send_word(ACT_INSERT, s, 16'(s + $urandom_range(0, 20) - 2),
                  16'($urandom_range(0, 7)), 0);
      end
      send_word(ACT_FIND, 0, 0, 16'($urandom_range(0, 9)), 0);
      send_word(ACT_REM_IDX, 0, 0, 0, 31);
      send_word(ACT_COALESCE, 0, 0, 0, 0);
    end

    for (int n = 0; n < RandWords;) begin
      if (n % 120 == 0) drain_and_set(3'($urandom_range(0, 7)));
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst; b++, n++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: begin
            if ($urandom_range(0, 3) == 0) begin
              s = rnd16(); e = rnd16();
            end else begin
              s = 16'($urandom_range(0, 15) * 16);
              e = 16'(s + $urandom_range(0, 31) - 1);
            end
            send_word(ACT_INSERT, s, e, $urandom_range(0, 3) == 0 ? rnd16() :
                      16'($urandom_range(0, 7)), 0);
          end
          8, 9: send_word(ACT_REM_HEAD, rnd16(), rnd16(), rnd16(), 5'($urandom()));
          10, 11, 12: send_word(ACT_REM_IDX, rnd16(), rnd16(), rnd16(), 5'($urandom()));
          13, 14, 15: send_word(ACT_FIND, rnd16(), rnd16(),
                                $urandom_range(0, 3) == 0 ? rnd16() : 16'($urandom_range(0, 7)),
                                5'($urandom()));
          16, 17: send_word(ACT_COALESCE, rnd16(), rnd16(), rnd16(), 5'($urandom()));
          18: send_word($urandom_range(0, 9) == 0 ? ACT_CLEAR :
                        ($urandom_range(0, 1) == 0 ? ACT_NOP6 : ACT_NOP7),
                        rnd16(), rnd16(), rnd16(), 5'($urandom()));
          default: send_word(ACT_INSERT, rnd16(), rnd16(), rnd16(), 5'($urandom()));
        endcase
      end
      if ($urandom_range(0, 2) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end

    start <= 0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("ran %0d command words, %0d result words checked, all insert orders",
             words_sent, results_seen);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/sbt_pkg.sv
rtl/sbt_ram.sv
rtl/sbt_ctrl.sv
rtl/sorted_block_table_with_coalesce_core.sv
rtl/sbt_checker.sv
dv/tb_top.sv
